// ----- rtl/core/mlcd_pkg.sv -----
package mlcd_pkg;

  localparam logic [7:0]  SYNC_FIRST      = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND     = 8'h5A;
  localparam logic [7:0]  CRC_POLY        = 8'h07;
  localparam logic [7:0]  CRC_INIT        = 8'h00;
  localparam logic [15:0] MAX_LEN_RESET   = 16'd4096;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_CRC_BAD  = 3'd2,
    KIND_OVERSIZE = 3'd3,
    KIND_ABORT    = 3'd4
  } kind_e;

  typedef struct packed {
    logic       link_drop;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [15:0] frame_length;
  } res_t;

  // CRC-8, MSB first, one byte folded in
  function automatic logic [7:0] crc8_upd(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] v;
    v = c ^ d;
    for (int i = 0; i < 8; i++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/mlcd_core.sv -----
module mlcd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        max_len_i,
  input  mlcd_pkg::item_t    item_i,
  input  logic               fire_i,
  output logic               has_res_o,
  output mlcd_pkg::res_t     res_o
);

  typedef enum logic [2:0] {
    PH_HUNT0   = 3'd0,
    PH_HUNT1   = 3'd1,
    PH_LENLO   = 3'd2,
    PH_LENHI   = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC     = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] frame_len_q, frame_len_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  crc_q, crc_d;

  logic [7:0]  b;
  logic [15:0] len;
  logic [15:0] left_dec;
  logic [7:0]  crc_next;

  assign b        = item_i.rx_byte;
  assign len      = {b, len_lo_q};
  assign left_dec = left_q - 16'd1;
  assign crc_next = mlcd_pkg::crc8_upd(crc_q, b);

  always_comb begin
    phase_d     = phase_q;
    len_lo_d    = len_lo_q;
    frame_len_d = frame_len_q;
    left_d      = left_q;
    crc_d       = crc_q;
    has_res_o   = 1'b0;
    res_o.kind         = mlcd_pkg::KIND_PAYLOAD;
    res_o.out_byte     = 8'd0;
    res_o.frame_length = frame_len_q;

    if (item_i.link_drop) begin
      phase_d = PH_HUNT0;
      case (phase_q)
        PH_LENLO, PH_LENHI, PH_PAYLOAD, PH_CRC: begin
          has_res_o  = 1'b1;
          res_o.kind = mlcd_pkg::KIND_ABORT;
        end
        default: ;
      endcase
    end else begin
      case (phase_q)
        PH_HUNT1: begin
          if (b == mlcd_pkg::SYNC_SECOND) begin
            phase_d     = PH_LENLO;
            frame_len_d = 16'd0;
            left_d      = 16'd0;
            crc_d       = mlcd_pkg::CRC_INIT;
          end else if (b == mlcd_pkg::SYNC_FIRST) begin
            phase_d = PH_HUNT1;
          end else begin
            phase_d = PH_HUNT0;
          end
        end
        PH_LENLO: begin
          len_lo_d = b;
          crc_d    = crc_next;
          phase_d  = PH_LENHI;
        end
        PH_LENHI: begin
          crc_d       = crc_next;
          frame_len_d = len;
          if (len > max_len_i) begin
            phase_d            = PH_HUNT0;
            has_res_o          = 1'b1;
            res_o.kind         = mlcd_pkg::KIND_OVERSIZE;
            res_o.frame_length = len;
          end else begin
            left_d  = len;
            phase_d = (len == 16'd0) ? PH_CRC : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_d     = crc_next;
          left_d    = left_dec;
          if (left_dec == 16'd0) begin
            phase_d = PH_CRC;
          end
          has_res_o      = 1'b1;
          res_o.out_byte = b;
        end
        PH_CRC: begin
          phase_d    = PH_HUNT0;
          has_res_o  = 1'b1;
          res_o.kind = (b == crc_q) ? mlcd_pkg::KIND_GOOD : mlcd_pkg::KIND_CRC_BAD;
        end
        default: begin
          // first sync hunt, unused codes behave the same
          phase_d = (b == mlcd_pkg::SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT0;
      len_lo_q    <= 8'd0;
      frame_len_q <= 16'd0;
      left_q      <= 16'd0;
      crc_q       <= mlcd_pkg::CRC_INIT;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      len_lo_q    <= len_lo_d;
      frame_len_q <= frame_len_d;
      left_q      <= left_d;
      crc_q       <= crc_d;
    end
  end

  // payload phase never sits with nothing left to count
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> left_q != 16'd0)
    else $error("payload phase with zero bytes left");

  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> left_q <= frame_len_q)
    else $error("bytes left exceeds frame length");

endmodule

// ----- rtl/core/magic_len_crc8_deframer.sv -----
// Channel   Dir  Fields (tdata/tuser from bit 0 up)
// s_axis    in   tdata: rx_byte[7:0]; tuser: link_drop
// m_axis    out  tdata: out_byte[7:0], frame_length[23:8]; tuser: kind; tlast: last
// cfg       in   cfg_data_i: max_payload_len
//
// One byte per cycle sustained while no byte that yields a result waits on a stalled
// result register. A byte is held in the input register while the core works on it, and
// its result is then held in the result register until it is taken on m_axis.
// Reset: asynchronous, active low; hunts for sync, max_payload_len = 4096.
// s_axis_tready drops only while a held byte that yields a result waits for a full,
// stalled result register.
module magic_len_crc8_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  input  logic        s_axis_tuser,   // link_drop
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_byte[7:0], frame_length[23:8]
  output logic [2:0]  m_axis_tuser,   // kind[2:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0]      max_len_q;
  logic             in_vld_q;
  mlcd_pkg::item_t  in_q;
  logic             out_vld_q;
  mlcd_pkg::res_t   out_q;

  logic             has_res;
  mlcd_pkg::res_t   res;
  logic             out_free;
  logic             fire;

  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && (!has_res || out_free);
  assign s_axis_tready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= mlcd_pkg::MAX_LEN_RESET;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.rx_byte   <= s_axis_tdata;
      in_q.link_drop <= s_axis_tuser;
    end
  end

  mlcd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .max_len_i (max_len_q),
    .item_i    (in_q),
    .fire_i    (fire),
    .has_res_o (has_res),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && has_res) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_res) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.frame_length, out_q.out_byte};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = (out_q.kind != mlcd_pkg::KIND_PAYLOAD);

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == mlcd_pkg::KIND_PAYLOAD ||
                       m_axis_tuser == mlcd_pkg::KIND_GOOD ||
                       m_axis_tuser == mlcd_pkg::KIND_CRC_BAD ||
                       m_axis_tuser == mlcd_pkg::KIND_OVERSIZE ||
                       m_axis_tuser == mlcd_pkg::KIND_ABORT))
    else $error("result kind out of range");

  a_end_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[7:0] == 8'd0)
    else $error("frame end carries a data byte");

  // a held result must not be overwritten before it is taken
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !(fire && has_res))
    else $error("result register overrun");

endmodule
